// ----- sv/cbhp_pkg.sv -----
// Shared types, codes and constants of the binary identifier header parser.
package cbhp_pkg;

  localparam int unsigned VALUE_W  = 63;
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [VALUE_W-1:0] CODE_VERSION  = VALUE_W'(64'h01);
  localparam logic [VALUE_W-1:0] CODE_RAW      = VALUE_W'(64'h55);
  localparam logic [VALUE_W-1:0] CODE_DAG_CBOR = VALUE_W'(64'h71);
  localparam logic [VALUE_W-1:0] CODE_IDENTITY = VALUE_W'(64'h00);
  localparam logic [VALUE_W-1:0] CODE_BLAKE2B  = VALUE_W'(64'hb220);
  localparam logic [VALUE_W-1:0] BLAKE2B_SIZE  = VALUE_W'(64'd32);

  localparam logic [3:0] VARINT_MAX_SHIFT = 4'd8;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_VARINT  = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_BAD_CONTENT = 3'd4,
    ST_BAD_HASH    = 3'd5,
    ST_BAD_SIZE    = 3'd6,
    ST_EXTRA_BYTES = 3'd7
  } status_t;

  // A byte as it leaves the front end, with its class already worked out.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       zero;
    logic       cont;
  } item_t;

  typedef struct packed {
    logic [7:0]         digest_byte;
    logic               digest_valid;
    logic               done_res;
    status_t            status;
    logic               content_kind;
    logic               hash_kind;
    logic [VALUE_W-1:0] digest_length;
  } result_t;

endpackage

// ----- sv/cbhp_front.sv -----
// Front end: accepts identifier bytes, classifies them and queues them.
module cbhp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [7:0]    in_byte,
  input  logic          in_is_last,
  output logic          full,
  output logic          deq_valid,
  output cbhp_pkg::item_t deq_item,
  input  logic          deq_take
);
  import cbhp_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               put;
  logic               get;
  item_t              cls;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign deq_valid = (cnt_r != '0);
  assign deq_item  = mem_r[rd_ptr_r];
  assign put       = push && !full;
  assign get       = deq_take && deq_valid;

  always_comb begin
    cls.data = in_byte;
    cls.last = in_is_last;
    cls.zero = (in_byte == 8'h00);
    cls.cont = in_byte[7];
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (put) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (get) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({put, get})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- sv/cbhp_core.sv -----
// Back end: varint decoding, phase tracking and the result queue.
module cbhp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  cbhp_pkg::item_t   item,
  output logic              item_take,
  output logic              empty,
  input  logic              pop,
  output cbhp_pkg::result_t res
);
  import cbhp_pkg::*;

  typedef enum logic [2:0] {
    PH_VERSION,
    PH_CONTENT,
    PH_HASH,
    PH_SIZE,
    PH_DIGEST,
    PH_EXTRA,
    PH_SINK
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               first_r, first_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [3:0]         shift_r, shift_nxt;
  logic               content_r, content_nxt;
  logic               hash_r, hash_nxt;
  logic [VALUE_W-1:0] size_r, size_nxt;
  logic [VALUE_W-1:0] remain_r, remain_nxt;
  status_t            pend_r, pend_nxt;

  logic [5:0]         sh;
  logic [VALUE_W-1:0] acc_or;
  logic [VALUE_W-1:0] remain_dec;
  result_t            res_c;

  result_t            q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               get;

  assign item_take = item_valid && (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign empty     = (cnt_r == '0);
  assign res       = q_r[rd_ptr_r];
  assign get       = pop && !empty;

  // Bit position of the current 7-bit group; the ninth group lands at the top.
  always_comb begin
    case (shift_r)
      4'd0:    sh = 6'd0;
      4'd1:    sh = 6'd7;
      4'd2:    sh = 6'd14;
      4'd3:    sh = 6'd21;
      4'd4:    sh = 6'd28;
      4'd5:    sh = 6'd35;
      4'd6:    sh = 6'd42;
      4'd7:    sh = 6'd49;
      default: sh = 6'd56;
    endcase
  end

  assign acc_or     = acc_r | (VALUE_W'(item.data[6:0]) << sh);
  assign remain_dec = remain_r - 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    first_nxt   = 1'b0;
    acc_nxt     = acc_r;
    shift_nxt   = shift_r;
    content_nxt = content_r;
    hash_nxt    = hash_r;
    size_nxt    = size_r;
    remain_nxt  = remain_r;
    pend_nxt    = pend_r;
    res_c       = '0;

    if (!(first_r && item.zero)) begin
      if (phase_r inside {PH_VERSION, PH_CONTENT, PH_HASH, PH_SIZE}) begin
        if (item.cont) begin
          if (shift_r >= VARINT_MAX_SHIFT) begin
            pend_nxt  = ST_BAD_VARINT;
            phase_nxt = PH_SINK;
            acc_nxt   = '0;
            shift_nxt = '0;
          end else begin
            acc_nxt   = acc_or;
            shift_nxt = shift_r + 1'b1;
          end
        end else if (item.zero && shift_r != 4'd0) begin
          pend_nxt  = ST_BAD_VARINT;
          phase_nxt = PH_SINK;
          acc_nxt   = '0;
          shift_nxt = '0;
        end else begin
          acc_nxt   = '0;
          shift_nxt = '0;
          case (phase_r)
            PH_VERSION: begin
              if (acc_or != CODE_VERSION) begin
                pend_nxt  = ST_BAD_VERSION;
                phase_nxt = PH_SINK;
              end else begin
                phase_nxt = PH_CONTENT;
              end
            end
            PH_CONTENT: begin
              content_nxt = (acc_or == CODE_DAG_CBOR);
              if (acc_or != CODE_RAW && acc_or != CODE_DAG_CBOR && pend_r == ST_OK) begin
                pend_nxt = ST_BAD_CONTENT;
              end
              phase_nxt = PH_HASH;
            end
            PH_HASH: begin
              hash_nxt = (acc_or == CODE_BLAKE2B);
              if (acc_or != CODE_IDENTITY && acc_or != CODE_BLAKE2B && pend_r == ST_OK) begin
                pend_nxt = ST_BAD_HASH;
              end
              phase_nxt = PH_SIZE;
            end
            default: begin
              size_nxt   = acc_or;
              remain_nxt = acc_or;
              if (hash_r && acc_or != BLAKE2B_SIZE && pend_r == ST_OK) begin
                pend_nxt = ST_BAD_SIZE;
              end
              phase_nxt = (acc_or != '0) ? PH_DIGEST : PH_EXTRA;
            end
          endcase
        end
      end else if (phase_r == PH_DIGEST) begin
        res_c.digest_byte  = item.data;
        res_c.digest_valid = (pend_r == ST_OK);
        remain_nxt         = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt = PH_EXTRA;
        end
      end else if (phase_r == PH_EXTRA) begin
        if (pend_r == ST_OK) begin
          pend_nxt = ST_EXTRA_BYTES;
        end
      end
    end

    res_c.done_res      = item.last;
    res_c.content_kind  = content_nxt;
    res_c.hash_kind     = hash_nxt;
    res_c.digest_length = size_nxt;
    if (item.last) begin
      if (phase_nxt inside {PH_VERSION, PH_CONTENT, PH_HASH, PH_SIZE}) begin
        res_c.status = ST_BAD_VARINT;
      end else if (phase_nxt == PH_DIGEST) begin
        res_c.status = ST_TRUNCATED;
      end else begin
        res_c.status = pend_nxt;
      end
    end else begin
      res_c.status = ST_OK;
    end
  end

  // The last byte of an identifier returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (!rst_n || (item_take && item.last)) begin
      phase_r   <= PH_VERSION;
      first_r   <= 1'b1;
      acc_r     <= '0;
      shift_r   <= '0;
      content_r <= 1'b0;
      hash_r    <= 1'b0;
      size_r    <= '0;
      remain_r  <= '0;
      pend_r    <= ST_OK;
    end else if (item_take) begin
      phase_r   <= phase_nxt;
      first_r   <= first_nxt;
      acc_r     <= acc_nxt;
      shift_r   <= shift_nxt;
      content_r <= content_nxt;
      hash_r    <= hash_nxt;
      size_r    <= size_nxt;
      remain_r  <= remain_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (item_take) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (get) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({item_take, get})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      q_r[wr_ptr_r] <= res_c;
    end
  end

endmodule

// ----- sv/cid_binary_header_parser.sv -----
// Top level of the binary identifier header parser: front end, parser core.
// A transferred byte passes through the front queue and then the result queue before its
// result can be popped from the output.
// Throughput: one byte per cycle while the result queue has room; the varint and phase update is combinational.
// Both sides are two-entry queues, so either side may stall without stopping the other until the queues fill.
// Reset is synchronous and active low; it empties both queues and clears parser state.
module cid_binary_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_digest_byte,
  output logic        out_digest_valid,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic        out_content_kind,
  output logic        out_hash_kind,
  output logic [62:0] out_digest_length
);
  import cbhp_pkg::*;

  logic    fq_valid;
  logic    fq_take;
  item_t   fq_item;
  result_t res;

  cbhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .full       (full),
    .deq_valid  (fq_valid),
    .deq_item   (fq_item),
    .deq_take   (fq_take)
  );

  cbhp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (fq_valid),
    .item       (fq_item),
    .item_take  (fq_take),
    .empty      (empty),
    .pop        (pop),
    .res        (res)
  );

  assign out_digest_byte   = res.digest_byte;
  assign out_digest_valid  = res.digest_valid;
  assign out_done_res      = res.done_res;
  assign out_status        = res.status;
  assign out_content_kind  = res.content_kind;
  assign out_hash_kind     = res.hash_kind;
  assign out_digest_length = res.digest_length;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fq_valid && !fq_take |=> fq_valid)
    else $error("queued byte lost between front end and core");

  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status != ST_OK |-> out_done_res)
    else $error("status reported on a result that is not the last");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full |=> fq_valid)
    else $error("transferred byte did not reach the front queue");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the binary identifier header parser.
`timescale 1ns / 1ps

module tb;
  import cbhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned CHUNK_BYTES = 225;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam logic [7:0] PREFIX_BYTE = 8'h00;

  typedef enum logic [2:0] {
    P_VERSION, P_CONTENT, P_HASH, P_SIZE, P_DIGEST, P_EXTRA, P_SINK
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        in_is_last = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_digest_byte;
  logic        out_digest_valid;
  logic        out_done_res;
  logic [2:0]  out_status;
  logic        out_content_kind;
  logic        out_hash_kind;
  logic [62:0] out_digest_length;

  // Stimulus waiting for the driver, and results the parser owes us.
  feed_t       byte_q[$];
  result_t     want_q[$];
  logic [7:0]  id_buf[$];

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned n_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_queued = 0;
  int unsigned n_sent = 0;
  int unsigned n_ids = 0;
  int unsigned n_checked = 0;
  int unsigned n_digest = 0;
  int unsigned status_count[8];

  // Parser state as the predictor sees it.
  parse_phase_t ph;
  logic         first_flag;
  logic [62:0]  acc;
  logic [3:0]   nbytes;
  logic         content_dag;
  logic         hash_blake;
  logic [62:0]  size_decl;
  logic [62:0]  remaining;
  status_t      pend;

  cid_binary_header_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .in_byte           (in_byte),
    .in_is_last        (in_is_last),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .out_digest_byte   (out_digest_byte),
    .out_digest_valid  (out_digest_valid),
    .out_done_res      (out_done_res),
    .out_status        (out_status),
    .out_content_kind  (out_content_kind),
    .out_hash_kind     (out_hash_kind),
    .out_digest_length (out_digest_length)
  );

  always #2 clk = ~clk;

  task automatic note_mismatch(string msg);
    n_errors++;
    $display("tb: mismatch at cycle %0d: %s", n_cycles, msg);
  endtask

  task automatic check_field(string name, logic [62:0] got, logic [62:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic clear_parse();
    ph = P_VERSION;
    first_flag = 1'b1;
    acc = '0;
    nbytes = '0;
    content_dag = 1'b0;
    hash_blake = 1'b0;
    size_decl = '0;
    remaining = '0;
    pend = ST_OK;
  endtask

  task automatic hard_fail(status_t code);
    pend = code;
    ph = P_SINK;
    acc = '0;
    nbytes = '0;
  endtask

  task automatic soft_fail(status_t code);
    if (pend == ST_OK) pend = code;
  endtask

  // Advances the header state by one accepted byte and queues the result it causes.
  task automatic parse_byte(logic [7:0] b, logic last);
    result_t     r;
    int unsigned sh;
    logic [62:0] v;
    r = '0;
    if (first_flag && b == PREFIX_BYTE) begin
      first_flag = 1'b0;
    end else begin
      first_flag = 1'b0;
      if (ph <= P_SIZE) begin
        sh = 7 * nbytes;
        if (sh > 56) sh = 56;
        acc = acc | (63'(b[6:0]) << sh);
        if (b[7]) begin
          if (nbytes >= VARINT_MAX_SHIFT) hard_fail(ST_BAD_VARINT);
          else nbytes++;
        end else if (b == 8'h00 && nbytes != 0) begin
          hard_fail(ST_BAD_VARINT);
        end else begin
          v = acc;
          acc = '0;
          nbytes = '0;
          case (ph)
            P_VERSION: begin
              if (v != CODE_VERSION) hard_fail(ST_BAD_VERSION);
              else ph = P_CONTENT;
            end
            P_CONTENT: begin
              content_dag = (v == CODE_DAG_CBOR);
              if (v != CODE_RAW && v != CODE_DAG_CBOR) soft_fail(ST_BAD_CONTENT);
              ph = P_HASH;
            end
            P_HASH: begin
              hash_blake = (v == CODE_BLAKE2B);
              if (v != CODE_IDENTITY && v != CODE_BLAKE2B) soft_fail(ST_BAD_HASH);
              ph = P_SIZE;
            end
            default: begin
              size_decl = v;
              if (hash_blake && v != BLAKE2B_SIZE) soft_fail(ST_BAD_SIZE);
              remaining = v;
              ph = (v != 0) ? P_DIGEST : P_EXTRA;
            end
          endcase
        end
      end else if (ph == P_DIGEST) begin
        r.digest_byte = b;
        r.digest_valid = (pend == ST_OK);
        remaining = remaining - 1'b1;
        if (remaining == 0) ph = P_EXTRA;
      end else if (ph == P_EXTRA) begin
        soft_fail(ST_EXTRA_BYTES);
      end
    end
    r.done_res = last;
    if (!last) r.status = ST_OK;
    else if (ph <= P_SIZE) r.status = ST_BAD_VARINT;
    else if (ph == P_DIGEST) r.status = ST_TRUNCATED;
    else r.status = pend;
    r.content_kind = content_dag;
    r.hash_kind = hash_blake;
    r.digest_length = size_decl;
    want_q.insert(want_q.size(), r);
    if (last) clear_parse();
  endtask

  // Canonical unsigned LEB128.
  task automatic put_varint(logic [62:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      id_buf.insert(id_buf.size(), b);
    end while (v != 0);
  endtask

  // Random varint of n bytes; ten bytes puts a continuation bit on the ninth.
  task automatic put_raw_varint(int unsigned n);
    for (int unsigned i = 1; i < n; i++) begin
      id_buf.insert(id_buf.size(), {1'b1, 7'($urandom_range(127))});
    end
    id_buf.insert(id_buf.size(),
                  {1'b0, ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(127))});
  endtask

  task automatic close_id();
    feed_t f;
    if (id_buf.size() == 0) id_buf.insert(0, 8'($urandom_range(255)));
    foreach (id_buf[i]) begin
      f.octet = id_buf[i];
      f.last = (i == id_buf.size() - 1);
      byte_q.insert(byte_q.size(), f);
    end
    n_queued += id_buf.size();
    n_ids++;
    id_buf.delete();
  endtask

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results still owed", n_cycles, want_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // Driver: a new byte goes out only after the previous one has been transferred, with random idle gaps.
  always @(posedge clk) begin
    feed_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
      clear_parse();
    end else begin
      if (push && !full) begin
        parse_byte(in_byte, in_is_last);
        n_sent++;
      end
      if (!push || !full) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_q.pop_front();
          push <= 1'b1;
          in_byte <= nxt.octet;
          in_is_last <= nxt.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: every transferred result is held against the oldest prediction.
  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (want_q.size() == 0) begin
          note_mismatch("result arrived with nothing predicted");
        end else begin
          w = want_q.pop_front();
          check_field("digest_byte", out_digest_byte, w.digest_byte);
          check_field("digest_valid", out_digest_valid, w.digest_valid);
          check_field("done_res", out_done_res, w.done_res);
          check_field("status", out_status, w.status);
          check_field("content_kind", out_content_kind, w.content_kind);
          check_field("hash_kind", out_hash_kind, w.hash_kind);
          check_field("digest_length", out_digest_length, w.digest_length);
          n_checked++;
          if (w.digest_valid) n_digest++;
          if (w.done_res) status_count[w.status]++;
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  initial begin
    int unsigned target;
    int unsigned r;
    int unsigned n_body;
    logic        blake;
    foreach (status_count[i]) status_count[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zero-length digest followed by a stray byte.
    put_varint(CODE_VERSION); put_varint(CODE_RAW); put_varint(CODE_IDENTITY);
    put_varint(63'd0); id_buf.insert(id_buf.size(), 8'hee); close_id();
    // Nothing but the prefix.
    id_buf.insert(id_buf.size(), PREFIX_BYTE); close_id();
    // Version other than one.
    put_varint(63'd2); close_id();
    // Varint closed by a zero byte.
    id_buf.insert(id_buf.size(), 8'h81); id_buf.insert(id_buf.size(), 8'h00); close_id();
    // Unknown content, blake2b with the wrong size; digest marked invalid.
    put_varint(CODE_VERSION); put_varint(63'h12); put_varint(CODE_BLAKE2B);
    put_varint(63'd1); id_buf.insert(id_buf.size(), 8'haa); close_id();
    // Unknown hash, then the digest ends early.
    put_varint(CODE_VERSION); put_varint(CODE_DAG_CBOR); put_varint(63'd7);
    put_varint(63'd2); id_buf.insert(id_buf.size(), 8'hff); close_id();
    // Continuation bit still set on the ninth byte.
    repeat (9) id_buf.insert(id_buf.size(), 8'hff);
    close_id();
    while (byte_q.size() != 0) @(posedge clk);

    for (int round = 0; round < 2; round++) begin
      for (int mode = 0; mode < 4; mode++) begin
        send_idle_pct = (mode == 1) ? 65 : (mode == 3) ? 14 : 0;
        pop_stall_pct = (mode == 2) ? 65 : (mode == 3) ? 14 : 0;
        target = n_queued + CHUNK_BYTES;
        while (n_queued < target) begin
          if ($urandom_range(99) < 25) begin
            // Noise: short runs of arbitrary bytes.
            repeat ($urandom_range(1, 12)) id_buf.insert(id_buf.size(), 8'($urandom_range(255)));
          end else begin
            if ($urandom_range(1) == 1) id_buf.insert(id_buf.size(), PREFIX_BYTE);
            if ($urandom_range(99) < 93) put_varint(CODE_VERSION);
            else put_raw_varint($urandom_range(1, 10));
            r = $urandom_range(99);
            if (r < 44) put_varint(CODE_RAW);
            else if (r < 88) put_varint(CODE_DAG_CBOR);
            else if (r < 94) put_raw_varint($urandom_range(1, 10));
            else put_varint(63'($urandom_range(255)));
            r = $urandom_range(99);
            blake = 1'b0;
            if (r < 55) put_varint(CODE_IDENTITY);
            else if (r < 85) begin
              put_varint(CODE_BLAKE2B);
              blake = 1'b1;
            end else if (r < 93) put_raw_varint($urandom_range(1, 10));
            else put_varint(63'($urandom_range(16'hffff)));
            r = $urandom_range(99);
            if (r < 85) begin
              n_body = blake ? 32'(BLAKE2B_SIZE) : $urandom_range(0, 8);
              if (blake && $urandom_range(9) == 0) n_body = $urandom_range(0, 40);
              put_varint(63'(n_body));
            end else begin
              // Wide sizes reach the top bits of the length; the digest then ends short.
              put_raw_varint(($urandom_range(1) == 1) ? 9 : $urandom_range(1, 10));
              n_body = $urandom_range(0, 6);
            end
            r = $urandom_range(99);
            if (r >= 88 && n_body != 0) n_body = n_body - $urandom_range(1, n_body);
            else if (r >= 75) n_body = n_body + $urandom_range(1, 3);
            repeat (n_body) id_buf.insert(id_buf.size(), 8'($urandom_range(255)));
            if ($urandom_range(99) < 6) begin
              n_body = $urandom_range(1, id_buf.size());
              id_buf = id_buf[0:n_body-1];
            end
          end
          close_id();
        end
        while (byte_q.size() != 0) @(posedge clk);
      end
    end

    send_idle_pct = 0;
    pop_stall_pct = 0;
    while (n_sent != n_queued || want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (want_q.size() != 0) note_mismatch("predicted results never arrived");

    $display("tb: %0d bytes in %0d identifiers, %0d results checked, %0d valid digest bytes",
             n_sent, n_ids, n_checked, n_digest);
    $display("tb: endings ok %0d ver %0d varint %0d trunc %0d content %0d",
             status_count[ST_OK], status_count[ST_BAD_VERSION], status_count[ST_BAD_VARINT],
             status_count[ST_TRUNCATED], status_count[ST_BAD_CONTENT]);
    $display("tb: endings hash %0d size %0d extra %0d",
             status_count[ST_BAD_HASH], status_count[ST_BAD_SIZE],
             status_count[ST_EXTRA_BYTES]);
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cbhp_pkg.sv
sv/cbhp_front.sv
sv/cbhp_core.sv
sv/cid_binary_header_parser.sv
tb/tb.sv
